@@ design/pgd_pkg.sv @@
// ----------------------------------------------------------------------------
// pgd_pkg
// Shared types and constants of the parking gap detector: result codes,
// configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package pgd_pkg;

	// configuration registers
	localparam int REG_W = 48;

	typedef logic [0:0] cfg_idx_t;

	localparam cfg_idx_t CFG_NEAR_GAP = 1'b0;
	localparam cfg_idx_t CFG_PARK_GAP = 1'b1;

	localparam logic [REG_W-1:0] NEAR_GAP_RESET = 48'd1048576;  // 4 m squared
	localparam logic [REG_W-1:0] PARK_GAP_RESET = 48'd9437184;  // 12 m squared

	// difference magnitudes are clamped to 2**CLAMP_LOG2 before squaring
	localparam int CLAMP_LOG2 = 25;

	// result codes
	localparam int STATUS_W = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_NONE  = 3'd0,  // no detection
		ST_FIRST = 3'd1,  // first detection stored
		ST_SAME  = 3'd2,  // same vehicle
		ST_NEW   = 3'd3,  // new vehicle, pair replaced
		ST_FOUND = 3'd4,  // parking spot found
		ST_DONE  = 3'd5   // spot already found earlier
	} status_t;

	typedef struct packed {
		status_t status;
		logic    brake;
	} verdict_t;

	localparam int USER_W = STATUS_W + 1;

endpackage

@@ design/pgd_dist.sv @@
// ----------------------------------------------------------------------------
// pgd_dist
// Squared distance between a detection and the stored detection: three
// clamped difference magnitudes, squared and summed.
// ----------------------------------------------------------------------------
module pgd_dist #(
	parameter int COORD_WIDTH = 24
) (
	input  logic signed [COORD_WIDTH-1:0] ax,
	input  logic signed [COORD_WIDTH-1:0] ay,
	input  logic signed [COORD_WIDTH-1:0] az,
	input  logic signed [COORD_WIDTH-1:0] bx,
	input  logic signed [COORD_WIDTH-1:0] by,
	input  logic signed [COORD_WIDTH-1:0] bz,
	output logic [2*((COORD_WIDTH + 1 > pgd_pkg::CLAMP_LOG2 + 1) ?
		pgd_pkg::CLAMP_LOG2 + 1 : COORD_WIDTH + 1) + 1:0] dist_sq
);

	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int CLAMP_W = pgd_pkg::CLAMP_LOG2 + 1;
	localparam int MAG_W = (DIFF_W > CLAMP_W) ? CLAMP_W : DIFF_W;
	localparam int SQ_W = 2 * MAG_W;
	localparam int SUM_W = SQ_W + 2;

	logic signed [COORD_WIDTH-1:0] a [3];
	logic signed [COORD_WIDTH-1:0] b [3];
	logic signed [DIFF_W-1:0] diff [3];
	logic [DIFF_W-1:0] mag [3];
	logic [MAG_W-1:0] mag_c [3];
	logic [SQ_W-1:0] sq [3];

	assign a[0] = ax;
	assign a[1] = ay;
	assign a[2] = az;
	assign b[0] = bx;
	assign b[1] = by;
	assign b[2] = bz;

	for (genvar i = 0; i < 3; i++) begin : g_axis
		assign diff[i] = {a[i][COORD_WIDTH-1], a[i]} - {b[i][COORD_WIDTH-1], b[i]};
		assign mag[i] = diff[i][DIFF_W-1] ? DIFF_W'(-diff[i]) : DIFF_W'(diff[i]);

		if (DIFF_W > CLAMP_W) begin : g_clamp
			localparam logic [DIFF_W-1:0] CLAMP_VAL = DIFF_W'(1) << pgd_pkg::CLAMP_LOG2;
			// saturate: any clamped value already exceeds every threshold
			assign mag_c[i] = (mag[i] > CLAMP_VAL) ? MAG_W'(CLAMP_VAL) : mag[i][MAG_W-1:0];
		end else begin : g_noclamp
			assign mag_c[i] = mag[i][MAG_W-1:0];
		end

		assign sq[i] = mag_c[i] * mag_c[i];
	end

	assign dist_sq = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);

endmodule

@@ design/pgd_track.sv @@
// ----------------------------------------------------------------------------
// pgd_track
// Stored detection pair, spot flag and the per-item decision. State advances
// at the edge where an item is processed.
// ----------------------------------------------------------------------------
module pgd_track #(
	parameter int COORD_WIDTH = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  logic signed [COORD_WIDTH-1:0] radar_x,
	input  logic signed [COORD_WIDTH-1:0] radar_y,
	input  logic signed [COORD_WIDTH-1:0] radar_z,
	input  logic signed [COORD_WIDTH-1:0] own_x,
	input  logic signed [COORD_WIDTH-1:0] own_y,
	input  logic signed [COORD_WIDTH-1:0] own_z,
	input  logic [pgd_pkg::REG_W-1:0] near_gap_squared,
	input  logic [pgd_pkg::REG_W-1:0] park_gap_squared,
	output pgd_pkg::verdict_t verdict,
	output logic signed [COORD_WIDTH-1:0] mid_x,
	output logic signed [COORD_WIDTH-1:0] mid_y,
	output logic signed [COORD_WIDTH-1:0] mid_z
);

	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int CLAMP_W = pgd_pkg::CLAMP_LOG2 + 1;
	localparam int MAG_W = (DIFF_W > CLAMP_W) ? CLAMP_W : DIFF_W;
	localparam int SUM_W = 2 * MAG_W + 2;
	localparam int CMP_W = (SUM_W > pgd_pkg::REG_W) ? SUM_W : pgd_pkg::REG_W;

	logic signed [COORD_WIDTH-1:0] other_x_q, other_y_q, other_z_q;
	logic signed [COORD_WIDTH-1:0] own_x_q, own_y_q, own_z_q;
	logic spot_found_q;

	logic [SUM_W-1:0] dist_sq;
	logic past_near, past_park, pair_empty;
	logic load_pair, set_found;
	logic signed [DIFF_W-1:0] sum_x, sum_y, sum_z;

	pgd_dist #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_dist (
		.ax     (radar_x),
		.ay     (radar_y),
		.az     (radar_z),
		.bx     (other_x_q),
		.by     (other_y_q),
		.bz     (other_z_q),
		.dist_sq(dist_sq)
	);

	assign past_near = CMP_W'(dist_sq) > CMP_W'(near_gap_squared);
	assign past_park = CMP_W'(dist_sq) > CMP_W'(park_gap_squared);

	// z takes no part in the empty test
	assign pair_empty = (own_x_q == '0) && (own_y_q == '0) &&
		(other_x_q == '0) && (other_y_q == '0);

	// floor of the half sum: drop the low bit of the widened sum
	assign sum_x = {own_x_q[COORD_WIDTH-1], own_x_q} + {other_x_q[COORD_WIDTH-1], other_x_q};
	assign sum_y = {own_y_q[COORD_WIDTH-1], own_y_q} + {other_y_q[COORD_WIDTH-1], other_y_q};
	assign sum_z = {own_z_q[COORD_WIDTH-1], own_z_q} + {other_z_q[COORD_WIDTH-1], other_z_q};

	always_comb begin
		verdict.status = pgd_pkg::ST_SAME;
		verdict.brake = 1'b0;
		mid_x = '0;
		mid_y = '0;
		mid_z = '0;
		load_pair = 1'b0;
		set_found = 1'b0;
		if (spot_found_q) begin
			verdict.status = pgd_pkg::ST_DONE;
		end else if (radar_x == '0 && radar_y == '0) begin
			verdict.status = pgd_pkg::ST_NONE;
		end else if (pair_empty) begin
			verdict.status = pgd_pkg::ST_FIRST;
			load_pair = 1'b1;
		end else if (past_near) begin
			if (past_park) begin
				verdict.status = pgd_pkg::ST_FOUND;
				verdict.brake = 1'b1;
				mid_x = sum_x[DIFF_W-1:1];
				mid_y = sum_y[DIFF_W-1:1];
				mid_z = sum_z[DIFF_W-1:1];
				set_found = 1'b1;
			end else begin
				verdict.status = pgd_pkg::ST_NEW;
				load_pair = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			other_x_q <= '0;
			other_y_q <= '0;
			other_z_q <= '0;
			own_x_q <= '0;
			own_y_q <= '0;
			own_z_q <= '0;
			spot_found_q <= 1'b0;
		end else if (fire) begin
			if (load_pair) begin
				other_x_q <= radar_x;
				other_y_q <= radar_y;
				other_z_q <= radar_z;
				own_x_q <= own_x;
				own_y_q <= own_y;
				own_z_q <= own_z;
			end
			if (set_found) begin
				spot_found_q <= 1'b1;
			end
		end
	end

endmodule

@@ design/parking_gap_detector.sv @@
// ----------------------------------------------------------------------------
// parking_gap_detector
// Pipeline: a taken beat passes through the input register, then the result
// register. Throughput: one beat per cycle while the sink does not stall; the
// distance squares, sum and threshold compares sit between the two registers.
// Reset: clears the stored detection pair, the spot flag and both pipeline
// valids, and loads the gap thresholds with 4 m and 12 m squared.
// ----------------------------------------------------------------------------
// Takes one radar detection plus own-vehicle position per beat and reports
// whether the detection belongs to the stored vehicle, starts a new one, or
// opens a parking gap wide enough to stop in. Once a gap is found every later
// beat reports "already found" until reset.
// ----------------------------------------------------------------------------
module parking_gap_detector #(
	parameter int COORD_WIDTH = 24
) (
	input  logic clk,
	input  logic arst_n,

	// input stream
	input  logic s_tvalid,
	output logic s_tready,
	// radar_x, radar_y, radar_z, own_x, own_y, own_z (lowest first), zero pad
	input  logic [((6 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,

	// result stream
	output logic m_tvalid,
	input  logic m_tready,
	// mid_x, mid_y, mid_z (lowest first), zero pad
	output logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
	// status [2:0], brake_request [3]
	output logic [pgd_pkg::USER_W-1:0] m_tuser,

	// configuration writes
	input  logic cfg_we,
	input  pgd_pkg::cfg_idx_t cfg_index,
	input  logic [pgd_pkg::REG_W-1:0] cfg_data
);

	localparam int OUT_W = ((3 * COORD_WIDTH + 7) / 8) * 8;

	// threshold registers
	logic [pgd_pkg::REG_W-1:0] near_gap_q, park_gap_q;

	// input register stage
	logic valid_s1;
	logic signed [COORD_WIDTH-1:0] radar_x_s1, radar_y_s1, radar_z_s1;
	logic signed [COORD_WIDTH-1:0] own_x_s1, own_y_s1, own_z_s1;

	// result register stage
	logic valid_s2;
	pgd_pkg::verdict_t verdict_s2;
	logic signed [COORD_WIDTH-1:0] mid_x_s2, mid_y_s2, mid_z_s2;

	// decision outputs of the current stage-1 item
	pgd_pkg::verdict_t verdict;
	logic signed [COORD_WIDTH-1:0] mid_x, mid_y, mid_z;

	logic advance, fire, take;

	// Advance the pipe whenever the result slot is free or being drained.
	// The stage-1 item is decided (and state updated) on the same edge it
	// moves into the result register, so the next item sees the new state.
	assign advance = !valid_s2 || m_tready;
	assign fire = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign take = s_tvalid && s_tready;

	// Configuration: write the addressed threshold, no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_gap_q <= pgd_pkg::NEAR_GAP_RESET;
			park_gap_q <= pgd_pkg::PARK_GAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pgd_pkg::CFG_NEAR_GAP: near_gap_q <= cfg_data;
				pgd_pkg::CFG_PARK_GAP: park_gap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1 valid: load on a taken beat, drop once the item has moved on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Stage 1 payload: unpack the beat, hold while stalled.
	always_ff @(posedge clk) begin
		if (take) begin
			radar_x_s1 <= s_tdata[0 * COORD_WIDTH +: COORD_WIDTH];
			radar_y_s1 <= s_tdata[1 * COORD_WIDTH +: COORD_WIDTH];
			radar_z_s1 <= s_tdata[2 * COORD_WIDTH +: COORD_WIDTH];
			own_x_s1 <= s_tdata[3 * COORD_WIDTH +: COORD_WIDTH];
			own_y_s1 <= s_tdata[4 * COORD_WIDTH +: COORD_WIDTH];
			own_z_s1 <= s_tdata[5 * COORD_WIDTH +: COORD_WIDTH];
		end
	end

	// Decision logic with the stored pair and spot flag.
	pgd_track #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_track (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.radar_x         (radar_x_s1),
		.radar_y         (radar_y_s1),
		.radar_z         (radar_z_s1),
		.own_x           (own_x_s1),
		.own_y           (own_y_s1),
		.own_z           (own_z_s1),
		.near_gap_squared(near_gap_q),
		.park_gap_squared(park_gap_q),
		.verdict         (verdict),
		.mid_x           (mid_x),
		.mid_y           (mid_y),
		.mid_z           (mid_z)
	);

	// Result register: fill on advance, hold while the sink stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			verdict_s2 <= verdict;
			mid_x_s2 <= mid_x;
			mid_y_s2 <= mid_y;
			mid_z_s2 <= mid_z;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = OUT_W'({mid_z_s2, mid_y_s2, mid_x_s2});
	assign m_tuser = {verdict_s2.brake, verdict_s2.status};

endmodule

@@ tb/tb_parking_gap_detector.sv @@
// ----------------------------------------------------------------------------
// tb_parking_gap_detector
// Self-checking bench for the parking gap detector. Drives radar and position
// beats with random stalls on both streams, predicts every verdict from an
// in-bench tracker of the stored detection pair, and checks status, brake and
// midpoint field by field. Sweeps the gap thresholds from zero to full scale.
// ----------------------------------------------------------------------------
module tb_parking_gap_detector;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_W  = 24;
	localparam int IN_W     = ((6 * COORD_W + 7) / 8) * 8;
	localparam int OUT_W    = ((3 * COORD_W + 7) / 8) * 8;
	localparam int REG_W    = pgd_pkg::REG_W;
	localparam int STATUS_W = pgd_pkg::STATUS_W;
	localparam int USER_W   = pgd_pkg::USER_W;

	localparam logic [REG_W-1:0] REG_MAX = '1;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	// radar_x sits in the lowest bits, same order as s_tdata
	typedef struct packed {
		coord_t own_z;
		coord_t own_y;
		coord_t own_x;
		coord_t radar_z;
		coord_t radar_y;
		coord_t radar_x;
	} sample_t;

	typedef struct {
		pgd_pkg::status_t status;
		logic    brake;
		coord_t  mid_x;
		coord_t  mid_y;
		coord_t  mid_z;
	} verdict_exp_t;

	// Tracks the stored detection pair and thresholds, and holds the verdicts
	// still owed by the block.
	class gap_tracker;
		logic [REG_W-1:0] near_sq = pgd_pkg::NEAR_GAP_RESET;
		logic [REG_W-1:0] park_sq = pgd_pkg::PARK_GAP_RESET;
		coord_t oth_x = '0, oth_y = '0, oth_z = '0;
		coord_t own_x = '0, own_y = '0, own_z = '0;
		bit spot_seen = 1'b0;
		verdict_exp_t pending[$];
		int mismatches = 0;
		int status_hits[6];

		function void set_reg(pgd_pkg::cfg_idx_t idx, logic [REG_W-1:0] val);
			case (idx)
				pgd_pkg::CFG_NEAR_GAP: near_sq = val;
				pgd_pkg::CFG_PARK_GAP: park_sq = val;
				default: ;
			endcase
		endfunction

		function longint unsigned axis_sq(coord_t a, coord_t b);
			longint d;
			longint unsigned m;
			d = longint'(a) - longint'(b);
			m = (d < 0) ? -d : d;
			if (m > (64'd1 << pgd_pkg::CLAMP_LOG2))
				m = 64'd1 << pgd_pkg::CLAMP_LOG2;
			return m * m;
		endfunction

		function longint unsigned spread_sq(sample_t smp);
			return axis_sq(smp.radar_x, oth_x) + axis_sq(smp.radar_y, oth_y)
				+ axis_sq(smp.radar_z, oth_z);
		endfunction

		// floor of the mean: arithmetic shift of the full-width sum
		function coord_t half_way(coord_t a, coord_t b);
			longint s;
			s = longint'(a) + longint'(b);
			return coord_t'(s >>> 1);
		endfunction

		function bit pair_empty();
			return oth_x == 0 && oth_y == 0 && own_x == 0 && own_y == 0;
		endfunction

		function void store(sample_t smp);
			oth_x = smp.radar_x;
			oth_y = smp.radar_y;
			oth_z = smp.radar_z;
			own_x = smp.own_x;
			own_y = smp.own_y;
			own_z = smp.own_z;
		endfunction

		function bit would_find_spot(sample_t smp);
			longint unsigned d2;
			if (spot_seen || (smp.radar_x == 0 && smp.radar_y == 0) || pair_empty())
				return 1'b0;
			d2 = spread_sq(smp);
			return d2 > {16'd0, near_sq} && d2 > {16'd0, park_sq};
		endfunction

		function void take_sample(sample_t smp);
			verdict_exp_t v;
			longint unsigned d2;
			v.status = pgd_pkg::ST_NONE;
			v.brake  = 1'b0;
			v.mid_x  = '0;
			v.mid_y  = '0;
			v.mid_z  = '0;
			if (spot_seen) begin
				v.status = pgd_pkg::ST_DONE;
			end else if (smp.radar_x == 0 && smp.radar_y == 0) begin
				v.status = pgd_pkg::ST_NONE;
			end else if (pair_empty()) begin
				store(smp);
				v.status = pgd_pkg::ST_FIRST;
			end else begin
				d2 = spread_sq(smp);
				if (d2 <= {16'd0, near_sq}) begin
					v.status = pgd_pkg::ST_SAME;
				end else if (d2 <= {16'd0, park_sq}) begin
					store(smp);
					v.status = pgd_pkg::ST_NEW;
				end else begin
					v.status  = pgd_pkg::ST_FOUND;
					v.brake   = 1'b1;
					v.mid_x   = half_way(own_x, oth_x);
					v.mid_y   = half_way(own_y, oth_y);
					v.mid_z   = half_way(own_z, oth_z);
					spot_seen = 1'b1;
				end
			end
			pending.push_back(v);
		endfunction

		function void report(string what, longint want, longint got);
			if (want != got) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %0d, got %0d",
					$time, what, want, got);
			end
		endfunction

		function void check_verdict(logic [OUT_W-1:0] data, logic [USER_W-1:0] user);
			verdict_exp_t v;
			coord_t got_x, got_y, got_z;
			got_x = data[COORD_W-1:0];
			got_y = data[2*COORD_W-1:COORD_W];
			got_z = data[3*COORD_W-1:2*COORD_W];
			if (pending.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, got status %0d",
					$time, user[STATUS_W-1:0]);
				return;
			end
			v = pending.pop_front();
			status_hits[int'(v.status)]++;
			report("status", int'(v.status), int'(user[STATUS_W-1:0]));
			report("brake_request", v.brake, user[STATUS_W]);
			report("mid_x", v.mid_x, got_x);
			report("mid_y", v.mid_y, got_y);
			report("mid_z", v.mid_z, got_z);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;  // radar_x, radar_y, radar_z, own_x, own_y, own_z

	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;      // mid_x, mid_y, mid_z
	logic [USER_W-1:0] m_tuser;     // status, brake_request

	logic cfg_we = 1'b0;
	pgd_pkg::cfg_idx_t cfg_index = pgd_pkg::CFG_NEAR_GAP;
	logic [REG_W-1:0] cfg_data = '0;

	gap_tracker tracker;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int beats_sent = 0;

	always #6 clk = ~clk;

	parking_gap_detector #(
		.COORD_WIDTH(COORD_W)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Receiver: stall at random, and hold ready low until reset is released.
	always @(negedge clk)
		m_tready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);

	// Check every result beat against the oldest owed verdict.
	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			tracker.check_verdict(m_tdata, m_tuser);

	function automatic sample_t mk(int rx, int ry, int rz, int ox, int oy, int oz);
		sample_t smp;
		smp.radar_x = coord_t'(rx);
		smp.radar_y = coord_t'(ry);
		smp.radar_z = coord_t'(rz);
		smp.own_x   = coord_t'(ox);
		smp.own_y   = coord_t'(oy);
		smp.own_z   = coord_t'(oz);
		return smp;
	endfunction

	function automatic coord_t jitter(coord_t base, int spread);
		int off;
		off = int'($urandom_range(0, 2 * spread)) - spread;
		return coord_t'(base + off);
	endfunction

	// Mostly detections that follow the stored vehicle or jump to the next
	// one; the rest are empty detections and full-range noise.
	function automatic sample_t pick_sample();
		sample_t smp;
		logic [5*32-1:0] noise;
		int roll;
		roll = $urandom_range(0, 99);
		smp.own_x = jitter(tracker.own_x, 2000);
		smp.own_y = jitter(tracker.own_y, 2000);
		smp.own_z = jitter(tracker.own_z, 100);
		if (roll < 6) begin
			smp.radar_x = '0;
			smp.radar_y = '0;
			smp.radar_z = coord_t'($urandom);
		end else if (roll < 18) begin
			noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
			smp = noise[$bits(sample_t)-1:0];
		end else if (roll < 70) begin
			smp.radar_x = jitter(tracker.oth_x, 200);
			smp.radar_y = jitter(tracker.oth_y, 200);
			smp.radar_z = jitter(tracker.oth_z, 50);
		end else begin
			smp.radar_x = jitter(tracker.oth_x, 6000);
			smp.radar_y = jitter(tracker.oth_y, 1500);
			smp.radar_z = jitter(tracker.oth_z, 100);
		end
		return smp;
	endfunction

	// Present one beat, with random idle cycles ahead of it; return at the
	// falling edge after the handshake.
	task automatic push_sample(sample_t smp);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'(smp);
		do
			@(posedge clk);
		while (!s_tready);
		tracker.take_sample(smp);
		beats_sent++;
		@(negedge clk);
	endtask

	// The spot can be found only once per reset, so before the last phase
	// hold the detection on the stored vehicle whenever it would end the run.
	task automatic offer_sample(sample_t smp, bit guard);
		if (guard && tracker.would_find_spot(smp)) begin
			smp.radar_x = tracker.oth_x;
			smp.radar_y = tracker.oth_y;
			smp.radar_z = tracker.oth_z;
		end
		push_sample(smp);
	endtask

	task automatic feed_random(int count, bit guard);
		repeat (count)
			offer_sample(pick_sample(), guard);
	endtask

	// Drop valid and wait until every owed verdict has arrived.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(pgd_pkg::cfg_idx_t idx, logic [REG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.set_reg(idx, val);
		@(negedge clk);
	endtask

	initial begin
		coord_t ext;
		sample_t smp;
		tracker = new();
		send_idle_pct = 35;
		recv_idle_pct = 62;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset thresholds: 1024**2 near, 3072**2 park. Hit both boundaries
		// exactly, where the compare must still say "not above".
		offer_sample(mk(0, 0, 0, 0, 0, 0), 1'b1);
		offer_sample(mk(0, 0, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX), 1'b1);
		offer_sample(mk(256, 0, 0, 512, -256, 0), 1'b1);
		offer_sample(mk(256, 1024, 0, 600, -256, 0), 1'b1);
		offer_sample(mk(256, 1025, 0, 768, -256, 16), 1'b1);
		offer_sample(mk(256, 4097, 0, -1024, 300, -5), 1'b1);
		offer_sample(mk(256, 4097, -1, -1000, 310, -5), 1'b1);
		offer_sample(mk(-100, 4097, 0, -990, 320, -5), 1'b1);

		// Any single-axis move is a new vehicle and never fits a spot: walk every axis
		// to both extremes with the others held on the stored point.
		drain();
		write_reg(pgd_pkg::CFG_NEAR_GAP, '0);
		write_reg(pgd_pkg::CFG_PARK_GAP, REG_MAX);
		offer_sample(mk(0, 0, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN), 1'b1);
		for (int axis = 0; axis < 3; axis++) begin
			for (int hi = 0; hi < 2; hi++) begin
				ext = hi ? COORD_MAX : COORD_MIN;
				smp = mk(tracker.oth_x, tracker.oth_y, tracker.oth_z, ext, ext, ext);
				case (axis)
					0: smp.radar_x = ext;
					1: smp.radar_y = ext;
					default: smp.radar_z = ext;
				endcase
				offer_sample(smp, 1'b1);
			end
		end
		feed_random(280, 1'b1);

		// Swap the stall pattern, random near threshold; pause the sender
		// midway until the pipeline has emptied.
		drain();
		send_idle_pct = 62;
		recv_idle_pct = 35;
		write_reg(pgd_pkg::CFG_NEAR_GAP, REG_W'($urandom_range(1 << 16, 1 << 24)));
		write_reg(pgd_pkg::CFG_PARK_GAP, REG_MAX);
		feed_random(200, 1'b1);
		drain();
		feed_random(200, 1'b1);

		// Full-rate streams; near at full scale, park below it.
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(pgd_pkg::CFG_NEAR_GAP, REG_MAX);
		write_reg(pgd_pkg::CFG_PARK_GAP, '0);
		feed_random(250, 1'b1);

		// Store a pair whose midpoints need floor rounding on negative odd
		// sums and reach both ends of the range, then let the spot be found.
		drain();
		write_reg(pgd_pkg::CFG_NEAR_GAP, '0);
		write_reg(pgd_pkg::CFG_PARK_GAP, REG_MAX);
		offer_sample(mk(-3, -5, 7, -2, COORD_MAX, COORD_MIN), 1'b1);
		drain();
		write_reg(pgd_pkg::CFG_NEAR_GAP, REG_W'(1 << 20));
		write_reg(pgd_pkg::CFG_PARK_GAP, REG_W'(1 << 10));
		feed_random(150, 1'b0);
		drain();

		$display("Run covered %0d beats; verdicts none/first/same/new/spot/after-spot:",
			beats_sent);
		$display("  %0d/%0d/%0d/%0d/%0d/%0d", tracker.status_hits[0],
			tracker.status_hits[1], tracker.status_hits[2], tracker.status_hits[3],
			tracker.status_hits[4], tracker.status_hits[5]);
		$display("Thresholds swept over zero, reset, random and full scale; %0d mismatches",
			tracker.mismatches);
		if (tracker.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("Timeout with %0d verdicts still owed", tracker.pending.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
